// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 30;
	localparam int EXT_W      = DATA_WIDTH + 3;      // branch terms, signed
	localparam int MAG_W      = 30;                  // normalized magnitude
	localparam int SUM_W      = 2 * MAG_W + 2;       // sum of four squares
	localparam int ROOT_W     = SUM_W / 2;           // sqrt result bits
	localparam int SREM_W     = ROOT_W + 3;          // sqrt remainder
	localparam int QUO_W      = 31;                  // divide quotient bits
	localparam int DREM_W     = ROOT_W + 1;          // divide remainder
	localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
	localparam int FRONT_N    = 5;
	localparam int STAGES     = FRONT_N + ROOT_W + QUO_W + 2;

	localparam logic [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] r00;
		logic signed [DATA_WIDTH-1:0] r01;
		logic signed [DATA_WIDTH-1:0] r02;
		logic signed [DATA_WIDTH-1:0] r10;
		logic signed [DATA_WIDTH-1:0] r11;
		logic signed [DATA_WIDTH-1:0] r12;
		logic signed [DATA_WIDTH-1:0] r20;
		logic signed [DATA_WIDTH-1:0] r21;
		logic signed [DATA_WIDTH-1:0] r22;
	} rmq_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_w;
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
		logic                         fell_back;
	} rmq_out_t;

	typedef struct packed {
		logic [3:0]              neg;
		logic [3:0][MAG_W-1:0]   mag;
		logic                    deg;
		logic [SUM_W-1:0]        rad;
		logic [SREM_W-1:0]       rem;
		logic [ROOT_W-1:0]       root;
	} sq_t;

	typedef struct packed {
		logic [3:0]              neg;
		logic                    deg;
		logic [ROOT_W-1:0]       norm;
		logic [3:0][DREM_W-1:0]  rem;
		logic [3:0][QUO_W-1:0]   num;
		logic [3:0][QUO_W-1:0]   quo;
	} dv_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a 3x3 Q2.30 rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage: present the nine matrix entries on in_data with in_valid; a word is
// taken when in_valid and in_ready are both high. The quaternion and the
// fell_back flag appear on out_data with out_valid and are taken with
// out_ready. Every input word gives exactly one output word, in order.
// From acceptance to out_valid a word passes through five front stages
// (branch, magnitude, normalize, square, sum), 31 square-root stages one
// result bit each, one divide setup stage, 31 divide stages one quotient bit
// each for the four components in parallel, and the output register.
// Throughput is one word per clock while out_ready does not stall the pipeline;
// the 30 x 30 square stage and the one-bit-per-stage root and divide set the depth.
// Each stage holds its word only while the one after it is full and stalled,
// so a stalled receiver backs words up stage by stage and bubbles fill in;
// nothing is dropped or repeated. Reset clears all stage valid bits, the
// pipeline comes up empty and in_ready high.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rmq_pkg::rmq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rmq_pkg::rmq_out_t out_data
);

	localparam int NS = rmq_pkg::STAGES;
	localparam int EW = rmq_pkg::EXT_W;
	localparam int MW = rmq_pkg::MAG_W;
	localparam int RW = rmq_pkg::ROOT_W;
	localparam int QW = rmq_pkg::QUO_W;
	localparam int DS = rmq_pkg::FRONT_N + RW;   // index of divide setup

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	// per-stage advance: a stage loads when it is empty or its successor loads
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[k-1 < 0 ? 0 : k-1];
				end
			end
		end
	end

	// ---------------- stage 1: branch select ----------------
	logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [EW-1:0] tr, one_x, rad;
	logic signed [EW-1:0] v_c [4];
	logic signed [EW-1:0] v_s1 [4];
	logic                 deg_s1;

	always_comb begin
		e00 = EW'(in_data.r00); e01 = EW'(in_data.r01); e02 = EW'(in_data.r02);
		e10 = EW'(in_data.r10); e11 = EW'(in_data.r11); e12 = EW'(in_data.r12);
		e20 = EW'(in_data.r20); e21 = EW'(in_data.r21); e22 = EW'(in_data.r22);
		one_x = EW'(signed'({1'b0, rmq_pkg::ONE_FX}));
		tr = e00 + e11 + e22;
		priority if (tr > 0) begin
			rad = tr + one_x;
			v_c[0] = rad; v_c[1] = e21 - e12; v_c[2] = e02 - e20; v_c[3] = e10 - e01;
		end else if (e00 > e11 && e00 > e22) begin
			rad = one_x + e00 - e11 - e22;
			v_c[0] = e21 - e12; v_c[1] = rad; v_c[2] = e01 + e10; v_c[3] = e02 + e20;
		end else if (e11 > e22) begin
			rad = one_x + e11 - e00 - e22;
			v_c[0] = e02 - e20; v_c[1] = e01 + e10; v_c[2] = rad; v_c[3] = e12 + e21;
		end else begin
			rad = one_x + e22 - e00 - e11;
			v_c[0] = e10 - e01; v_c[1] = e02 + e20; v_c[2] = e12 + e21; v_c[3] = rad;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1   <= v_c;
			deg_s1 <= (rad <= 0);
		end
	end

	// ---------------- stage 2: magnitudes and largest ----------------
	logic [EW-1:0] mg_c [4];
	logic [EW-1:0] mx01, mx23;
	logic [EW-1:0] mag_s2 [4];
	logic [EW-1:0] max_s2;
	logic [3:0]    neg_s2;
	logic          deg_s2;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mg_c[i] = v_s1[i][EW-1] ? EW'(-v_s1[i]) : EW'(v_s1[i]);
		end
		mx01 = (mg_c[0] > mg_c[1]) ? mg_c[0] : mg_c[1];
		mx23 = (mg_c[2] > mg_c[3]) ? mg_c[2] : mg_c[3];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_s2 <= mg_c;
			max_s2 <= (mx01 > mx23) ? mx01 : mx23;
			for (int i = 0; i < 4; i++) neg_s2[i] <= v_s1[i][EW-1];
			deg_s2 <= deg_s1;
		end
	end

	// ---------------- stage 3: common shift into [2^29, 2^30) ----------------
	localparam int TOP = MW - 1;
	logic [5:0]    msb;
	logic [MW-1:0] sh_c [4];
	logic [MW-1:0] mag_s3 [4];
	logic [3:0]    neg_s3;
	logic          deg_s3;

	always_comb begin
		msb = '0;
		for (int b = 0; b < EW; b++) begin
			if (max_s2[b]) msb = 6'(b);
		end
		for (int i = 0; i < 4; i++) begin
			if (msb >= 6'(TOP)) sh_c[i] = MW'(mag_s2[i] >> (msb - 6'(TOP)));
			else                sh_c[i] = MW'(mag_s2[i] << (6'(TOP) - msb));
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mag_s3 <= sh_c;
			neg_s3 <= neg_s2;
			deg_s3 <= deg_s2;
		end
	end

	// ---------------- stage 4: squares ----------------
	logic [2*MW-1:0] sq_s4 [4];
	logic [MW-1:0]   mag_s4 [4];
	logic [3:0]      neg_s4;
	logic            deg_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 4; i++) sq_s4[i] <= mag_s3[i] * mag_s3[i];
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
		end
	end

	// ---------------- stage 5: sum of squares ----------------
	rmq_pkg::sq_t sq_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sq_s5.rad  <= rmq_pkg::SUM_W'(sq_s4[0]) + rmq_pkg::SUM_W'(sq_s4[1])
			            + rmq_pkg::SUM_W'(sq_s4[2]) + rmq_pkg::SUM_W'(sq_s4[3]);
			for (int i = 0; i < 4; i++) sq_s5.mag[i] <= mag_s4[i];
			sq_s5.neg  <= neg_s4;
			sq_s5.deg  <= deg_s4;
			sq_s5.rem  <= '0;
			sq_s5.root <= '0;
		end
	end

	// ---------------- square root: one result bit per stage ----------------
	rmq_pkg::sq_t sq_st [RW+1];
	assign sq_st[0] = sq_s5;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		rmq_pkg::sq_t            nx;
		logic [rmq_pkg::SREM_W-1:0] rs, trial;

		always_comb begin
			nx    = sq_st[j];
			rs    = {sq_st[j].rem[rmq_pkg::SREM_W-3:0], sq_st[j].rad[rmq_pkg::SUM_W-1 -: 2]};
			trial = {1'b0, sq_st[j].root, 2'b01};
			nx.rad = {sq_st[j].rad[rmq_pkg::SUM_W-3:0], 2'b00};
			if (rs >= trial) begin
				nx.rem  = rs - trial;
				nx.root = {sq_st[j].root[RW-2:0], 1'b1};
			end else begin
				nx.rem  = rs;
				nx.root = {sq_st[j].root[RW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[rmq_pkg::FRONT_N + j]) sq_st[j+1] <= nx;
		end
	end

	// ---------------- divide setup ----------------
	rmq_pkg::dv_t                dv_st [QW+1];
	rmq_pkg::dv_t                dset;
	logic [rmq_pkg::NUM_W-1:0]   numer;

	always_comb begin
		dset.neg  = sq_st[RW].neg;
		dset.norm = sq_st[RW].root;
		dset.deg  = sq_st[RW].deg || (sq_st[RW].root == '0);
		dset.quo  = '0;
		numer     = '0;
		for (int i = 0; i < 4; i++) begin
			numer = {1'b0, sq_st[RW].mag[i], rmq_pkg::FRAC_BITS'(0)}
			      + rmq_pkg::NUM_W'(sq_st[RW].root >> 1);
			dset.rem[i] = rmq_pkg::DREM_W'(numer[rmq_pkg::NUM_W-1:QW]);
			dset.num[i] = numer[QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[DS]) dv_st[0] <= dset;
	end

	// ---------------- divide: one quotient bit per stage, four lanes ----------------
	for (genvar j = 0; j < QW; j++) begin : g_div
		rmq_pkg::dv_t nx;
		logic [rmq_pkg::DREM_W:0] rs [4];

		always_comb begin
			nx = dv_st[j];
			for (int i = 0; i < 4; i++) begin
				rs[i] = {dv_st[j].rem[i], dv_st[j].num[i][QW-1]};
				nx.num[i] = {dv_st[j].num[i][QW-2:0], 1'b0};
				if (rs[i] >= {1'b0, 1'b0, dv_st[j].norm}) begin
					nx.rem[i] = rmq_pkg::DREM_W'(rs[i] - {2'b00, dv_st[j].norm});
					nx.quo[i] = {dv_st[j].quo[i][QW-2:0], 1'b1};
				end else begin
					nx.rem[i] = rmq_pkg::DREM_W'(rs[i]);
					nx.quo[i] = {dv_st[j].quo[i][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[DS + 1 + j]) dv_st[j+1] <= nx;
		end
	end

	// ---------------- output register: signs and fallback ----------------
	localparam int DW = rmq_pkg::DATA_WIDTH;
	logic [DW-1:0]     q_c [4];
	rmq_pkg::rmq_out_t res_c;
	rmq_pkg::rmq_out_t out_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			q_c[i] = DW'(dv_st[QW].quo[i]);
			if (dv_st[QW].neg[i]) q_c[i] = DW'(-q_c[i]);
		end
		if (dv_st[QW].deg) begin
			res_c.quat_w    = rmq_pkg::ONE_FX;
			res_c.quat_x    = '0;
			res_c.quat_y    = '0;
			res_c.quat_z    = '0;
			res_c.fell_back = 1'b1;
		end else begin
			res_c.quat_w    = q_c[0];
			res_c.quat_x    = q_c[1];
			res_c.quat_y    = q_c[2];
			res_c.quat_z    = q_c[3];
			res_c.fell_back = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) out_q <= res_c;
	end

	assign out_valid = vld_q[NS-1];
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fell_back |-> out_data.quat_w == rmq_pkg::ONE_FX
		&& out_data.quat_x == '0 && out_data.quat_y == '0 && out_data.quat_z == '0)
		else $error("fallback without identity quaternion");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted word missing from first stage");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.quat_w <= signed'(rmq_pkg::ONE_FX)
		&& out_data.quat_w >= -signed'(rmq_pkg::ONE_FX))
		else $error("scalar part beyond unit magnitude");

endmodule
